// ===== rtl/ppct_pkg.sv =====
package ppct_pkg;

	localparam int unsigned MaxRowsDef = 64;
	localparam int unsigned MaxColsDef = 16;

	localparam int unsigned RowSelW = 6;
	localparam int unsigned ColSelW = 4;
	localparam int unsigned ValW    = 32;
	localparam int unsigned RowsCfgW = 7;
	localparam int unsigned ColsCfgW = 5;

	// Q16.16 products are Q32.32; sums and shifted bounds fit in this width.
	localparam int unsigned AccW = 96;

	localparam logic [31:0] HalfQ = 32'h0000_8000;

	typedef enum logic [2:0] {
		ACT_COEF  = 3'd0,
		ACT_BOUND = 3'd1,
		ACT_OFFS  = 3'd2,
		ACT_POINT = 3'd3,
		ACT_QUERY = 3'd4
	} action_t;

	typedef enum logic {
		REG_ROWS = 1'b0,
		REG_COLS = 1'b1
	} cfg_reg_t;

	// One accepted item as it travels from the front part to the back part.
	typedef struct packed {
		logic [2:0]         action;
		logic [RowSelW-1:0] row_sel;
		logic [ColSelW-1:0] col_sel;
		logic [ValW-1:0]    value;
		logic               query_kind;
	} cmd_t;

endpackage

// ===== rtl/ppct_ram.sv =====
module ppct_ram #(
	parameter int unsigned Width = 32,
	parameter int unsigned Depth = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);

	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/ppct_front.sv =====
module ppct_front
	import ppct_pkg::*;
#(
	parameter int unsigned QDepth = 2
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [2:0]         action,
	input  logic [RowSelW-1:0] row_sel,
	input  logic [ColSelW-1:0] col_sel,
	input  logic [ValW-1:0]    value,
	input  logic               query_kind,
	output logic               cmd_valid,
	output cmd_t               cmd,
	input  logic               cmd_pop
);

	localparam int unsigned PtrW = (QDepth > 1) ? $clog2(QDepth) : 1;

	cmd_t            fifo_q [QDepth];
	logic [PtrW-1:0] wr_q;
	logic [PtrW-1:0] rd_q;
	logic [PtrW:0]   cnt_q;
	logic            push;
	logic            keep;

	// Items that change nothing and give no result are dropped right here.
	always_comb begin
		keep = (action == ACT_COEF) || (action == ACT_BOUND) || (action == ACT_OFFS)
			|| (action == ACT_POINT) || (action == ACT_QUERY);
	end

	assign busy      = (cnt_q == (PtrW+1)'(QDepth));
	assign push      = start && !busy && keep;
	assign cmd_valid = (cnt_q != '0);
	assign cmd       = fifo_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_q] <= '{action: action, row_sel: row_sel, col_sel: col_sel,
				value: value, query_kind: query_kind};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PtrW'(QDepth-1)) ? '0 : wr_q + 1'b1;
			end
			if (cmd_pop) begin
				rd_q <= (rd_q == PtrW'(QDepth-1)) ? '0 : rd_q + 1'b1;
			end
			cnt_q <= cnt_q + (PtrW+1)'(push) - (PtrW+1)'(cmd_pop);
		end
	end

endmodule

// ===== rtl/ppct_back.sv =====
module ppct_back
	import ppct_pkg::*;
#(
	parameter int unsigned MaxRows = MaxRowsDef,
	parameter int unsigned MaxCols = MaxColsDef
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	input  cmd_t                cmd,
	output logic                cmd_pop,
	input  logic [RowsCfgW-1:0] rows_cfg,
	input  logic [ColsCfgW-1:0] cols_cfg,
	output logic                idle,
	output logic                done,
	output logic                kind_done,
	output logic                answer
);

	localparam int unsigned RowW  = (MaxRows > 1) ? $clog2(MaxRows) : 1;
	localparam int unsigned ColW  = (MaxCols > 1) ? $clog2(MaxCols) : 1;
	localparam int unsigned ProdW = 64;
	localparam int unsigned SumW  = ProdW + ColW + 1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN
	} state_t;

	state_t state_q;

	// Row and column counts saturate into range; zero counts as one.
	logic [RowW:0] rows_n;
	logic [ColW:0] cols_n;
	always_comb begin
		if (rows_cfg == '0) begin
			rows_n = (RowW+1)'(1);
		end else if (32'(rows_cfg) > MaxRows) begin
			rows_n = (RowW+1)'(MaxRows);
		end else begin
			rows_n = (RowW+1)'(rows_cfg);
		end
		if (cols_cfg == '0) begin
			cols_n = (ColW+1)'(1);
		end else if (32'(cols_cfg) > MaxCols) begin
			cols_n = (ColW+1)'(MaxCols);
		end else begin
			cols_n = (ColW+1)'(cols_cfg);
		end
	end

	// Decode of the head command.
	logic row_ok;
	logic col_ok;
	assign row_ok = (32'(cmd.row_sel) < MaxRows);
	assign col_ok = (32'(cmd.col_sel) < MaxCols);

	logic is_query;
	assign is_query = (cmd.action == ACT_QUERY);
	assign cmd_pop  = cmd_valid && (state_q == ST_IDLE);

	logic we_coef, we_bound, we_offs, we_point;
	assign we_coef  = cmd_pop && (cmd.action == ACT_COEF) && row_ok && col_ok;
	assign we_bound = cmd_pop && (cmd.action == ACT_BOUND) && row_ok;
	assign we_offs  = cmd_pop && (cmd.action == ACT_OFFS) && row_ok;
	assign we_point = cmd_pop && (cmd.action == ACT_POINT) && col_ok;

	logic [RowW-1:0] wrow;
	logic [ColW-1:0] wcol;
	assign wrow = RowW'(cmd.row_sel);
	assign wcol = ColW'(cmd.col_sel);

	// Point registers and offset valid bits.
	logic [ValW-1:0] point_q [MaxCols];
	logic [MaxRows-1:0] offs_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < MaxCols; j++) begin
				point_q[j] <= '0;
			end
			offs_vld_q <= '0;
		end else begin
			if (we_point) begin
				point_q[wcol] <= cmd.value;
			end
			if (we_offs) begin
				offs_vld_q[wrow] <= 1'b1;
			end
		end
	end

	// Row counter that walks the stores during a query.
	logic [RowW:0]   ridx_q;
	logic            kind_q;
	logic            stop_q;
	logic            touch_q;
	logic [RowW-1:0] raddr;
	assign raddr = RowW'(ridx_q);

	// Coefficient rows: one RAM per column, so one row is read in a cycle.
	logic [ValW-1:0] coef_rd [MaxCols];
	logic [ValW-1:0] bound_rd;
	logic [ValW-1:0] offs_rd;

	for (genvar j = 0; j < MaxCols; j++) begin : g_col
		ppct_ram #(.Width(ValW), .Depth(MaxRows)) u_coef (
			.clk  (clk),
			.we   (we_coef && (wcol == ColW'(j))),
			.waddr(wrow),
			.wdata(cmd.value),
			.raddr(raddr),
			.rdata(coef_rd[j])
		);
	end

	ppct_ram #(.Width(ValW), .Depth(MaxRows)) u_bound (
		.clk  (clk),
		.we   (we_bound),
		.waddr(wrow),
		.wdata(cmd.value),
		.raddr(raddr),
		.rdata(bound_rd)
	);

	ppct_ram #(.Width(ValW), .Depth(MaxRows)) u_offs (
		.clk  (clk),
		.we   (we_offs),
		.waddr(wrow),
		.wdata(cmd.value),
		.raddr(raddr),
		.rdata(offs_rd)
	);

	// Stage 1: read issued (ridx), data returns with this row tag.
	logic            v_s1;
	logic            last_s1;
	logic            ovld_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			last_s1 <= 1'b0;
			ovld_s1 <= 1'b0;
		end else begin
			v_s1    <= (state_q == ST_RUN);
			last_s1 <= (state_q == ST_RUN) && (ridx_q == rows_n - 1'b1);
			ovld_s1 <= offs_vld_q[raddr];
		end
	end

	// Operand vector: point or unit-cell center.
	logic signed [ValW-1:0] opnd [MaxCols];
	always_comb begin
		for (int j = 0; j < MaxCols; j++) begin
			if (kind_q) begin
				opnd[j] = (point_q[j] & 32'hFFFF_0000) + HalfQ;
			end else begin
				opnd[j] = point_q[j];
			end
		end
	end

	// Stage 2: one multiplier per dimension.
	logic signed [ProdW-1:0] prod_s2 [MaxCols];
	logic signed [ValW-1:0]  bound_s2;
	logic signed [ValW-1:0]  offs_s2;
	logic                    v_s2;
	logic                    last_s2;
	always_ff @(posedge clk) begin
		for (int j = 0; j < MaxCols; j++) begin
			if (32'(j) < 32'(cols_n)) begin
				prod_s2[j] <= $signed(coef_rd[j]) * opnd[j];
			end else begin
				prod_s2[j] <= '0;
			end
		end
		bound_s2 <= bound_rd;
		offs_s2  <= ovld_s1 ? offs_rd : '0;
	end

	// Stage 3: sum of products and limits.
	logic signed [SumW-1:0] sum_c;
	always_comb begin
		sum_c = '0;
		for (int j = 0; j < MaxCols; j++) begin
			sum_c = sum_c + SumW'(prod_s2[j]);
		end
	end

	logic signed [AccW-1:0] dot_s3;
	logic signed [AccW-1:0] b_s3;
	logic signed [AccW-1:0] o_s3;
	logic                   v_s3;
	logic                   last_s3;
	always_ff @(posedge clk) begin
		dot_s3 <= AccW'(sum_c);
		b_s3   <= AccW'(bound_s2) <<< 16;
		o_s3   <= AccW'(offs_s2) <<< 16;
	end

	// Stage 4 logic: the comparisons of the row.
	logic signed [AccW-1:0] d2;
	logic signed [AccW-1:0] lim1;
	logic signed [AccW-1:0] lim2;
	logic                   row_out;
	logic                   row_touch;
	always_comb begin
		d2   = dot_s3 <<< 1;
		lim1 = (b_s3 <<< 1) - o_s3;
		lim2 = lim1 - (o_s3 <<< 1);
		if (kind_q) begin
			row_out   = d2 > lim1;
			row_touch = !(lim2 > d2);
		end else begin
			row_out   = dot_s3 > b_s3;
			row_touch = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2    <= 1'b0;
			last_s2 <= 1'b0;
			v_s3    <= 1'b0;
			last_s3 <= 1'b0;
		end else begin
			v_s2    <= v_s1;
			last_s2 <= last_s1;
			v_s3    <= v_s2;
			last_s3 <= last_s2;
		end
	end

	// Sequencer and registered result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			ridx_q    <= '0;
			kind_q    <= 1'b0;
			stop_q    <= 1'b0;
			touch_q   <= 1'b0;
			done      <= 1'b0;
			kind_done <= 1'b0;
			answer    <= 1'b0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_pop && is_query) begin
						state_q <= ST_RUN;
						ridx_q  <= '0;
						kind_q  <= cmd.query_kind;
						stop_q  <= 1'b0;
						touch_q <= 1'b0;
					end
				end
				ST_RUN: begin
					if (ridx_q == rows_n - 1'b1) begin
						state_q <= ST_DRAIN;
					end else begin
						ridx_q <= ridx_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					if (v_s3 && last_s3) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (v_s3) begin
				if (row_out) begin
					stop_q <= 1'b1;
				end
				if (row_touch) begin
					touch_q <= 1'b1;
				end
				if (last_s3) begin
					done      <= 1'b1;
					kind_done <= kind_q;
					if (stop_q || row_out) begin
						answer <= 1'b0;
					end else begin
						answer <= kind_q ? (touch_q || row_touch) : 1'b1;
					end
				end
			end
		end
	end

	assign idle = (state_q == ST_IDLE) && !cmd_valid;

endmodule

// ===== rtl/polytope_point_and_cell_test_top.sv =====
// Writes are performed as the back part takes them from the queue; a query over R rows
// walks its rows through the read, multiply, sum and compare stages, then raises its result strobe.
// Throughput: one query occupies the row sequencer until its last row has drained (one row a cycle);
// writes wait while a query runs. A two-entry command queue decouples start from the sequencer.
// Reset: arst_n clears the queue, the sequencer, the point registers, the offset valid bits
// and the counts (rows_q and cols_q become one). Results cannot be stalled.
module polytope_point_and_cell_test_top
	import ppct_pkg::*;
#(
	parameter int unsigned MaxRows = MaxRowsDef,
	parameter int unsigned MaxCols = MaxColsDef
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [2:0]          action,
	input  logic [RowSelW-1:0]  row_sel,
	input  logic [ColSelW-1:0]  col_sel,
	input  logic [ValW-1:0]     value,
	input  logic                query_kind,
	output logic                done,
	output logic                kind_done,
	output logic                answer,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic                cfg_index,
	input  logic [31:0]         cfg_data
);

	// Configuration registers. Writes must happen only while the block is idle; the block
	// itself does not enforce this. cfg_ready is always high.
	logic [RowsCfgW-1:0] rows_q;
	logic [ColsCfgW-1:0] cols_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= RowsCfgW'(1);
			cols_q <= ColsCfgW'(1);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_ROWS: rows_q <= cfg_data[RowsCfgW-1:0];
				REG_COLS: cols_q <= cfg_data[ColsCfgW-1:0];
				default:  rows_q <= rows_q;
			endcase
		end
	end

	// The front part takes each transaction into a short queue; the back part
	// performs writes and runs queries row by row through the stores.
	logic cmd_valid;
	logic cmd_pop;
	cmd_t cmd;
	logic idle;

	ppct_front #(.QDepth(2)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.action    (action),
		.row_sel   (row_sel),
		.col_sel   (col_sel),
		.value     (value),
		.query_kind(query_kind),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop)
	);

	ppct_back #(.MaxRows(MaxRows), .MaxCols(MaxCols)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd      (cmd),
		.cmd_pop  (cmd_pop),
		.rows_cfg (rows_q),
		.cols_cfg (cols_q),
		.idle     (idle),
		.done     (done),
		.kind_done(kind_done),
		.answer   (answer)
	);

	// A result strobe lasts a single cycle.
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held for two cycles");

	// No result appears while nothing has been queued or is in flight.
	a_done_not_idle: assert property (@(posedge clk) disable iff (!arst_n)
		$past(idle) && idle |-> !done)
		else $error("result without a pending query");

	// The queue is never popped when it is empty.
	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> cmd_valid)
		else $error("queue popped while empty");

endmodule
